FILE: hdl/spq_pkg.sv
// Package with the shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH = 16;
  // Wide enough to hold the count of a full queue.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [1:0] new_role;
    logic [3:0] new_level;
  } spq_in_t;

  typedef struct packed {
    logic       popped_valid;
    logic [1:0] popped_role;
    logic [3:0] popped_level;
    logic       overflow;
    logic [4:0] entry_count;
  } spq_out_t;

  typedef struct packed {
    logic [1:0] role;
    logic [3:0] level;
  } spq_entry_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic       ins;
    logic       pop;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage

FILE: hdl/spq_cell.sv
// One cell of the sorted row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  spq_ctrl_t  ctrl_i,
  input  logic       occ_i,
  input  logic       left_take_i,
  input  spq_entry_t left_entry_i,
  input  spq_entry_t right_entry_i,
  output spq_entry_t entry_o,
  output logic       take_o
);

  spq_entry_t entry_q, entry_d;

  // A cell takes part in an insert when it is empty or holds a level that
  // the new entry goes in front of. Along the row this forms a thermometer.
  assign take_o = !occ_i || (entry_q.level <= ctrl_i.new_entry.level);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && take_o) begin
      // The first taking cell stores the new entry, the rest shift right.
      entry_d = left_take_i ? left_entry_i : ctrl_i.new_entry;
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: hdl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell row, fill count and result register.
`timescale 1ns / 1ps

// Usage notes.
// A command is transferred at a rising edge where start is high and busy is
// low. Command remove pops the highest-level entry; command insert places the
// new entry in front of the first stored entry whose level is lower or equal,
// so among equal levels the newest entry leaves first.
// The result appears on result_o in the cycle after the transfer, for exactly
// one cycle, marked by valid_o; the receiver takes it at the edge ending that
// cycle and cannot hold it off.
// Every command completes without a stall: all cells compare against the new level in
// parallel and shift by one place toward or away from the head, so busy
// stays low and a command may be given in every cycle.
// An insert into a full queue is dropped and reported with overflow set; a
// remove from an empty queue reports popped_valid low. entry_count is the
// number of entries held after the command.
// Reset empties the queue and clears valid_o; the entry contents are left as
// they are, as only cells below the fill count are ever read.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  cmd_i,
  output logic     valid_o,
  output spq_out_t result_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             valid_q;
  spq_out_t         result_q, result_d;

  spq_ctrl_t        ctrl;
  spq_entry_t       entries [DEPTH];
  logic [DEPTH-1:0] take;
  logic [DEPTH-1:0] occ;
  logic             accept, full, empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  assign ctrl.ins = accept && (cmd_i.command == CMD_INSERT) && !full;
  assign ctrl.pop = accept && (cmd_i.command == CMD_REMOVE) && !empty;
  assign ctrl.new_entry.role  = cmd_i.new_role;
  assign ctrl.new_entry.level = cmd_i.new_level;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_entry, right_entry;
    logic       left_take;

    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_entry = ctrl.new_entry;
    end else begin : g_body
      assign left_take  = take[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .left_take_i   (left_take),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .take_o        (take[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end

    result_d              = '0;
    result_d.overflow     = accept && (cmd_i.command == CMD_INSERT) && full;
    result_d.entry_count  = 5'(count_d);
    if (ctrl.pop) begin
      result_d.popped_valid = 1'b1;
      result_d.popped_role  = entries[0].role;
      result_d.popped_level = entries[0].level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  cmd_i = '0;
  logic     valid_o;
  spq_out_t result_o;

  sorted_priority_queue_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the queue, kept in service order with the head at index 0.
  spq_entry_t  shadow_entries [DEPTH];
  int unsigned shadow_fill = 0;

  spq_out_t    pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cmd_count      = 0;
  int unsigned result_count   = 0;
  int unsigned pop_count      = 0;
  int unsigned empty_pop_count = 0;
  int unsigned overflow_count = 0;
  int unsigned peak_fill      = 0;
  bit          idle_enable    = 1'b0;
  int unsigned idle_odds      = 4;

  function automatic spq_out_t predict_queue_op(input spq_in_t c);
    spq_out_t   r;
    spq_entry_t e;
    int unsigned pos;
    bit         found;
    r = '0;
    if (c.command == CMD_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        r.overflow = 1'b1;
        overflow_count++;
      end else begin
        pos   = shadow_fill;
        found = 1'b0;
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          if (!found && shadow_entries[i].level <= c.new_level) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int unsigned i = shadow_fill; i > pos; i--)
          shadow_entries[i] = shadow_entries[i - 1];
        e.role  = c.new_role;
        e.level = c.new_level;
        shadow_entries[pos] = e;
        shadow_fill++;
      end
    end else if (shadow_fill > 0) begin
      r.popped_valid = 1'b1;
      r.popped_role  = shadow_entries[0].role;
      r.popped_level = shadow_entries[0].level;
      for (int unsigned i = 1; i < shadow_fill; i++)
        shadow_entries[i - 1] = shadow_entries[i];
      shadow_fill--;
      pop_count++;
    end else begin
      empty_pop_count++;
    end
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.entry_count = shadow_fill[4:0];
    return r;
  endfunction

  function automatic spq_in_t make_insert(input logic [1:0] role, input logic [3:0] level);
    spq_in_t c;
    c.command   = CMD_INSERT;
    c.new_role  = role;
    c.new_level = level;
    return c;
  endfunction

  // The role and level fields of a remove are don't-care, so they carry noise.
  function automatic spq_in_t make_remove();
    spq_in_t c;
    c = spq_in_t'($urandom);
    c.command = CMD_REMOVE;
    return c;
  endfunction

  // Mostly legal levels; now and then the whole 4-bit range.
  function automatic logic [3:0] random_level();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    cmd_i <= spq_in_t'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_cmd(input spq_in_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_queue_op(c));
    cmd_count++;
    if (idle_enable && $urandom_range(1, idle_odds) == 1)
      idle_cycles($urandom_range(1, 7));
  endtask

  task automatic report_mismatch(input string what, input spq_out_t want, input spq_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected v=%0b r=%0d l=%0d ovf=%0b cnt=%0d, got v=%0b r=%0d l=%0d ovf=%0b cnt=%0d",
               $realtime, what, want.popped_valid, want.popped_role, want.popped_level,
               want.overflow, want.entry_count, got.popped_valid, got.popped_role,
               got.popped_level, got.overflow, got.entry_count);
  endtask

  // Each result is taken at the edge that ends its strobe cycle.
  always @(posedge clk_i) begin
    spq_out_t want;
    if (rst_ni && valid_o) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command pending", '0, result_o);
      end else begin
        want = pending_results.pop_front();
        if (result_o.popped_valid !== want.popped_valid ||
            result_o.popped_role  !== want.popped_role  ||
            result_o.popped_level !== want.popped_level ||
            result_o.overflow     !== want.overflow     ||
            result_o.entry_count  !== want.entry_count)
          report_mismatch("result mismatch", want, result_o);
      end
    end
  end

  // Remove from empty, out-of-range levels, ties in the middle and at the head.
  task automatic test_directed_order();
    send_cmd(make_remove());
    send_cmd(make_insert(2'd1, 4'd8));
    send_cmd(make_insert(2'd2, 4'd1));
    send_cmd(make_insert(2'd3, 4'd15));
    send_cmd(make_insert(2'd0, 4'd0));
    send_cmd(make_insert(2'd1, 4'd5));
    send_cmd(make_insert(2'd2, 4'd5));
    send_cmd(make_insert(2'd3, 4'd5));
    send_cmd(make_insert(2'd2, 4'd15));
    repeat (9) send_cmd(make_remove());
  endtask

  // Fill past full so the rejected inserts show up, then drain past empty.
  task automatic test_fill_and_drain(input int unsigned rounds);
    for (int unsigned r = 0; r < rounds; r++) begin
      while (shadow_fill < DEPTH)
        send_cmd(make_insert(2'($urandom), random_level()));
      repeat ($urandom_range(1, 3)) send_cmd(make_insert(2'($urandom), random_level()));
      while (shadow_fill > 0) begin
        if ($urandom_range(0, 5) == 0)
          send_cmd(make_insert(2'($urandom), random_level()));
        else
          send_cmd(make_remove());
      end
      send_cmd(make_remove());
    end
  endtask

  // Chunks with a shifting insert bias walk the count between empty and full.
  task automatic test_random_mix(input int unsigned chunks, input int unsigned chunk_len);
    int unsigned insert_pct;
    for (int unsigned k = 0; k < chunks; k++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      idle_odds = $urandom_range(0, 3) == 0 ? 1000 : $urandom_range(2, 6);
      repeat (chunk_len) begin
        if ($urandom_range(1, 100) <= insert_pct)
          send_cmd(make_insert(2'($urandom), random_level()));
        else
          send_cmd(make_remove());
      end
    end
    idle_odds = 4;
  endtask

  task automatic test_back_to_back(input int unsigned n);
    idle_enable = 1'b0;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        send_cmd(make_insert(2'($urandom), random_level()));
      else
        send_cmd(make_remove());
    end
  endtask

  initial begin
    int unsigned guard;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_enable = 1'b1;
    test_directed_order();
    test_fill_and_drain(3);
    test_random_mix(10, 30);
    test_back_to_back(120);
    start <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (5) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end

    $display("Sent %0d commands and checked %0d results with %0d mismatches.",
             cmd_count, result_count, mismatch_count);
    $display("Covered %0d pops, %0d pops from empty, %0d rejected inserts, peak fill %0d.",
             pop_count, empty_pop_count, overflow_count, peak_fill);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
